// File: design/assert_macros.svh
// Assertion helper macros shared by the hasher RTL.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that must hold on every clock outside reset.
`define SHABS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("shabs assertion failed");
// Condition that must never be seen outside reset.
`define SHABS_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("shabs forbidden condition seen");
`endif

// File: design/shabs_pkg.sv
// Shared types and constants for the SHA-256 byte stream hasher.
// No dependencies; imported by every module of the block.
package shabs_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int DIGEST_W        = 256;
    localparam int COUNT_W         = 61;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } cmd_t;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

// File: design/shabs_front.sv
// Input side: accepts beats, drops idle beats and queues commands.
// Depends on shabs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module shabs_front #(
    parameter int DEPTH = shabs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_valid,
    output logic               s_ready,
    input  shabs_pkg::cmd_t    s_cmd,
    output logic               cmd_valid,
    output shabs_pkg::cmd_t    cmd,
    input  logic               cmd_ready
);
    import shabs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t               queue_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push;
    logic               pop;

    assign s_ready   = (count_reg != CNT_W'(DEPTH));
    assign push      = s_valid && s_ready && (s_cmd.byte_present || s_cmd.end_of_message);
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign pop       = cmd_valid && cmd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= s_cmd;
        end
    end

    `SHABS_ASSERT(a_count_up, (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
    `SHABS_ASSERT(a_count_down, (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))

endmodule

// File: design/shabs_back.sv
// Back end: block assembly, padding, 64-round compression, digest register.
// Depends on shabs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module shabs_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    input  shabs_pkg::cmd_t                   cmd,
    output logic                              cmd_ready,
    output logic                              out_valid,
    output logic [shabs_pkg::DIGEST_W-1:0]    out_data,
    input  logic                              out_ready
);
    import shabs_pkg::*;

    typedef enum logic [2:0] {ST_IDLE, ST_PAD, ST_COMP, ST_SUM, ST_OUT} state_t;

    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] FILL_LEN   = 6'd56;
    localparam logic [5:0] ROUND_LAST = 6'd63;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction

    state_t               state_reg;
    logic [5:0]           fill_reg;
    logic [5:0]           round_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic                 pad_first_reg;
    logic                 pad_active_reg;
    logic                 len_phase_reg;
    logic                 last_block_reg;
    logic                 out_valid_reg;
    logic [31:0]          hash_reg [8];
    logic [31:0]          v_reg [8];
    logic [31:0]          w_reg [16];
    logic [23:0]          word_reg;
    logic [DIGEST_W-1:0]  out_data_reg;

    logic                 feed_en;
    logic [7:0]           feed_byte;
    logic [7:0]           pad_byte;
    logic                 len_now;
    logic [63:0]          len_shift;
    logic                 start_comp;
    logic                 out_load;
    logic [31:0]          v_next [8];
    logic [31:0]          w_next;
    logic [31:0]          t1;
    logic [31:0]          t2;
    logic [DIGEST_W-1:0]  digest_flat;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // padding byte stream: 0x80, zeros, then the big-endian bit length
    assign len_now   = len_phase_reg || (!pad_first_reg && fill_reg == FILL_LEN);
    assign len_shift = {count_reg, 3'b000} << {fill_reg[2:0], 3'b000};
    assign pad_byte  = pad_first_reg ? 8'h80 : (len_now ? len_shift[63:56] : 8'h00);

    assign feed_en    = (state_reg == ST_PAD) ||
                        (state_reg == ST_IDLE && cmd_valid && cmd.byte_present);
    assign feed_byte  = (state_reg == ST_PAD) ? pad_byte : cmd.data_byte;
    assign start_comp = feed_en && (fill_reg == FILL_LAST);
    assign out_load   = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        logic [31:0] e;
        logic [31:0] a;
        logic [31:0] ch;
        logic [31:0] maj;
        e   = v_reg[4];
        a   = v_reg[0];
        ch  = (e & v_reg[5]) ^ (~e & v_reg[6]);
        maj = (a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1  = v_reg[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ch
              + ROUND_K[round_reg] + w_reg[0];
        t2  = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + maj;
        v_next[0] = t1 + t2;
        v_next[1] = v_reg[0];
        v_next[2] = v_reg[1];
        v_next[3] = v_reg[2];
        v_next[4] = v_reg[3] + t1;
        v_next[5] = v_reg[4];
        v_next[6] = v_reg[5];
        v_next[7] = v_reg[6];
        w_next = w_reg[0] + w_reg[9]
                 + (rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3))
                 + (rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10));
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            digest_flat[64*i +: 64] = {hash_reg[2*i], hash_reg[2*i+1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            round_reg      <= '0;
            count_reg      <= '0;
            pad_first_reg  <= 1'b0;
            pad_active_reg <= 1'b0;
            len_phase_reg  <= 1'b0;
            last_block_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            hash_reg       <= INIT_HASH;
        end
        else
        begin
            if (feed_en)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        if (cmd.byte_present)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        if (start_comp)
                        begin
                            state_reg      <= ST_COMP;
                            round_reg      <= '0;
                            pad_active_reg <= cmd.end_of_message;
                            pad_first_reg  <= cmd.end_of_message;
                        end
                        else if (cmd.end_of_message)
                        begin
                            state_reg      <= ST_PAD;
                            pad_active_reg <= 1'b1;
                            pad_first_reg  <= 1'b1;
                        end
                    end
                end
                ST_PAD:
                begin
                    pad_first_reg <= 1'b0;
                    if (len_now)
                    begin
                        len_phase_reg <= 1'b1;
                    end
                    if (start_comp)
                    begin
                        state_reg      <= ST_COMP;
                        round_reg      <= '0;
                        last_block_reg <= len_phase_reg;
                    end
                end
                ST_COMP:
                begin
                    round_reg <= round_reg + 1'b1;
                    if (round_reg == ROUND_LAST)
                    begin
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        hash_reg[i] <= hash_reg[i] + v_reg[i];
                    end
                    if (last_block_reg)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else if (pad_active_reg)
                    begin
                        state_reg <= ST_PAD;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg      <= ST_IDLE;
                        hash_reg       <= INIT_HASH;
                        count_reg      <= '0;
                        pad_active_reg <= 1'b0;
                        len_phase_reg  <= 1'b0;
                        last_block_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (feed_en)
        begin
            word_reg <= {word_reg[15:0], feed_byte};
            if (fill_reg[1:0] == 2'd3)
            begin
                for (int j = 0; j < 15; j++)
                begin
                    w_reg[j] <= w_reg[j+1];
                end
                w_reg[15] <= {word_reg, feed_byte};
            end
        end
        else if (state_reg == ST_COMP)
        begin
            for (int j = 0; j < 15; j++)
            begin
                w_reg[j] <= w_reg[j+1];
            end
            w_reg[15] <= w_next;
            v_reg     <= v_next;
        end
        if (start_comp)
        begin
            v_reg <= hash_reg;
        end
        if (out_load)
        begin
            out_data_reg <= digest_flat;
        end
    end

    `SHABS_ASSERT(a_round_end,
        (state_reg == ST_COMP && round_reg == ROUND_LAST) |=> (state_reg == ST_SUM))
    `SHABS_ASSERT(a_digest_clears,
        out_load |=> (count_reg == '0 && fill_reg == '0 && out_valid_reg))

endmodule

// File: design/sha256_byte_stream_hasher.sv
// SHA-256 byte stream hasher, top level.
// Channels: s_axis carries one optional message byte per beat (tuser = byte
// present, tlast = end of message); m_axis carries one 256-bit digest.
// A beat with neither a byte nor tlast is accepted and ignored.
// Input beats go into a short command queue; the back end takes one byte per
// cycle from the queue into the 64-byte block while it is idle, and runs one
// compression round per cycle; it takes no bytes while a block is compressed.
// After tlast the back end feeds 0x80, zeros and the length one byte per
// cycle (up to 72 bytes) and compresses one or two blocks; the digest is then
// loaded into the output register once that register is free.
// Digest bytes 0..7 are big-endian in tdata[63:0], bytes 24..31 in
// tdata[255:192]. After a digest the hash restarts for a new message.
// Reset clears the queue and the byte count and loads the initial hash values.
// While m_axis is stalled the digest is held; the queue and the back end keep
// taking beats, and the back end waits only before loading a following digest.
// Depends on shabs_pkg, shabs_front and shabs_back.
module sha256_byte_stream_hasher #(
    parameter int QUEUE_DEPTH = shabs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tuser,   // [0] byte_present
    input  logic         s_axis_tlast,   // end_of_message
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [255:0] m_axis_tdata    // digest_part_0 .. digest_part_3, 64 bits each
);
    import shabs_pkg::*;

    cmd_t   in_cmd;
    cmd_t   q_cmd;
    logic   q_valid;
    logic   q_ready;

    assign in_cmd.data_byte      = s_axis_tdata;
    assign in_cmd.byte_present   = s_axis_tuser;
    assign in_cmd.end_of_message = s_axis_tlast;

    shabs_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_cmd     (in_cmd),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_ready (q_ready)
    );

    shabs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_ready (q_ready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_ready (m_axis_tready)
    );

endmodule
